[hw/rtl/crc16_packet_deframer_core_macros.svh]
// assertion helpers shared by the deframer modules
`ifndef CRC16_PACKET_DEFRAMER_CORE_MACROS_SVH
`define CRC16_PACKET_DEFRAMER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define CPD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication, checked outside reset
`define CPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

[hw/rtl/cpd_pkg.sv]
package cpd_pkg;

    // default payload ceiling of the core
    localparam int MAX_PAYLOAD_DEF = 256;

    // largest value the 9-bit limit register can hold
    localparam int CFG_LIMIT_MAX = 511;

    // register reset values
    localparam logic [7:0] START_MARKER_RST  = 8'hAA;
    localparam logic [8:0] PAYLOAD_LIMIT_RST = 9'd256;

    // crc-16/ccitt-false
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // register indexes
    localparam logic REG_START_MARKER  = 1'b0;
    localparam logic REG_PAYLOAD_LIMIT = 1'b1;

    // parser phase
    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_CMD     = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC_LO  = 3'd5,
        PH_CRC_HI  = 3'd6
    } phase_t;

    // kind of result word
    typedef enum logic [1:0] {
        EV_PAYLOAD  = 2'd0,
        EV_GOOD     = 2'd1,
        EV_CRC_BAD  = 2'd2,
        EV_TOO_LONG = 2'd3
    } event_t;

    // one result word
    typedef struct packed {
        event_t      event_res;
        logic [7:0]  command;
        logic [15:0] frame_length;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
        logic        last;
    } res_t;

    // byte-wide crc update, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/cpd_parser.sv]
module cpd_parser #(
    parameter int MAX_PAYLOAD = cpd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic [7:0]       rx_byte,
    input  logic [7:0]       start_marker,
    input  logic [8:0]       payload_limit,
    output logic             res_valid,
    output cpd_pkg::res_t    res
);

    // count only has to reach the effective limit
    localparam int LIM_MAX = (MAX_PAYLOAD < cpd_pkg::CFG_LIMIT_MAX) ?
                             MAX_PAYLOAD : cpd_pkg::CFG_LIMIT_MAX;
    localparam int CNT_W   = $clog2(LIM_MAX + 1);

    cpd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       command_reg, command_next;
    logic [15:0]      length_reg, length_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crc_lo_reg, crc_lo_next;

    logic [15:0]      crc_upd;
    logic [15:0]      len_full;
    logic [15:0]      eff_limit;
    logic [CNT_W-1:0] count_inc;
    logic [15:0]      pos16;
    logic [15:0]      rx_crc;

    // shared datapath terms
    assign crc_upd   = cpd_pkg::crc_byte(crc_reg, rx_byte);
    assign len_full  = {rx_byte, length_reg[7:0]};
    assign eff_limit = (16'(payload_limit) > 16'(MAX_PAYLOAD)) ?
                       16'(MAX_PAYLOAD) : 16'(payload_limit);
    assign count_inc = count_reg + 1'b1;
    assign pos16     = 16'(count_reg);
    assign rx_crc    = {rx_byte, crc_lo_reg};

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        command_next = command_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        crc_lo_next  = crc_lo_reg;
        if (in_fire)
        begin
            case (phase_reg)
                cpd_pkg::PH_START:
                begin
                    if (rx_byte == start_marker)
                    begin
                        phase_next   = cpd_pkg::PH_CMD;
                        command_next = 8'h00;
                        length_next  = 16'h0000;
                        count_next   = '0;
                        crc_lo_next  = 8'h00;
                        crc_next     = cpd_pkg::CRC_INIT;
                    end
                end
                cpd_pkg::PH_CMD:
                begin
                    command_next = rx_byte;
                    crc_next     = crc_upd;
                    phase_next   = cpd_pkg::PH_LEN_LO;
                end
                cpd_pkg::PH_LEN_LO:
                begin
                    length_next = {8'h00, rx_byte};
                    crc_next    = crc_upd;
                    phase_next  = cpd_pkg::PH_LEN_HI;
                end
                cpd_pkg::PH_LEN_HI:
                begin
                    length_next = len_full;
                    crc_next    = crc_upd;
                    count_next  = '0;
                    if (len_full > eff_limit)
                    begin
                        phase_next = cpd_pkg::PH_START;
                    end
                    else if (len_full == 16'h0000)
                    begin
                        phase_next = cpd_pkg::PH_CRC_LO;
                    end
                    else
                    begin
                        phase_next = cpd_pkg::PH_PAYLOAD;
                    end
                end
                cpd_pkg::PH_PAYLOAD:
                begin
                    crc_next   = crc_upd;
                    count_next = count_inc;
                    if (16'(count_inc) >= length_reg)
                    begin
                        phase_next = cpd_pkg::PH_CRC_LO;
                    end
                end
                cpd_pkg::PH_CRC_LO:
                begin
                    crc_lo_next = rx_byte;
                    phase_next  = cpd_pkg::PH_CRC_HI;
                end
                cpd_pkg::PH_CRC_HI:
                begin
                    phase_next = cpd_pkg::PH_START;
                end
                default:
                begin
                    phase_next = cpd_pkg::PH_START;
                end
            endcase
        end
    end

    // result word for the byte being taken
    always_comb
    begin
        res_valid        = 1'b0;
        res.event_res    = cpd_pkg::EV_PAYLOAD;
        res.command      = command_reg;
        res.frame_length = length_reg;
        res.data_byte    = 8'h00;
        res.byte_index   = 8'h00;
        res.computed_crc = 16'h0000;
        res.received_crc = 16'h0000;
        res.last         = 1'b0;
        if (in_fire)
        begin
            case (phase_reg)
                cpd_pkg::PH_LEN_HI:
                begin
                    if (len_full > eff_limit)
                    begin
                        res_valid        = 1'b1;
                        res.event_res    = cpd_pkg::EV_TOO_LONG;
                        res.frame_length = len_full;
                        res.last         = 1'b1;
                    end
                end
                cpd_pkg::PH_PAYLOAD:
                begin
                    res_valid      = 1'b1;
                    res.data_byte  = rx_byte;
                    res.byte_index = pos16[7:0];
                end
                cpd_pkg::PH_CRC_HI:
                begin
                    res_valid        = 1'b1;
                    res.event_res    = (crc_reg == rx_crc) ?
                                       cpd_pkg::EV_GOOD : cpd_pkg::EV_CRC_BAD;
                    res.computed_crc = crc_reg;
                    res.received_crc = rx_crc;
                    res.last         = 1'b1;
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    // phase and count carry control meaning, the rest is held data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cpd_pkg::PH_START;
            count_reg <= '0;
            crc_reg   <= cpd_pkg::CRC_INIT;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        command_reg <= command_next;
        length_reg  <= length_next;
        crc_lo_reg  <= crc_lo_next;
    end

`include "crc16_packet_deframer_core_macros.svh"

    `CPD_ASSERT_IMPL(a_res_needs_fire, res_valid, in_fire)
    `CPD_ASSERT_IMPL(a_payload_in_range, phase_reg == cpd_pkg::PH_PAYLOAD, (16'(count_reg) < length_reg))
    `CPD_ASSERT_IMPL(a_last_on_status, res_valid, (res.last == (res.event_res != cpd_pkg::EV_PAYLOAD)))

endmodule

[hw/rtl/cpd_outbuf.sv]
module cpd_outbuf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cpd_pkg::res_t push_data,
    output logic          space,
    output logic          out_valid,
    input  logic          out_ready,
    output cpd_pkg::res_t out_data
);

    logic          main_v_reg, main_v_next;
    logic          skid_v_reg, skid_v_next;
    cpd_pkg::res_t main_reg, main_next;
    cpd_pkg::res_t skid_reg, skid_next;
    logic          main_free;

    assign main_free = !main_v_reg || out_ready;
    assign space     = !skid_v_reg;
    assign out_valid = main_v_reg;
    assign out_data  = main_reg;

    // output word plus one spare slot
    always_comb
    begin
        main_v_next = main_v_reg;
        skid_v_next = skid_v_reg;
        main_next   = main_reg;
        skid_next   = skid_reg;
        if (main_free)
        begin
            if (skid_v_reg)
            begin
                main_next   = skid_reg;
                main_v_next = 1'b1;
                skid_v_next = 1'b0;
            end
            else if (push)
            begin
                main_next   = push_data;
                main_v_next = 1'b1;
            end
            else
            begin
                main_v_next = 1'b0;
            end
        end
        else if (push)
        begin
            skid_next   = push_data;
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            main_v_reg <= main_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

`include "crc16_packet_deframer_core_macros.svh"

    `CPD_ASSERT_IMPL(a_skid_behind_main, skid_v_reg, main_v_reg)
    `CPD_ASSERT_IMPL(a_no_push_when_full, skid_v_reg, !push)
    `CPD_ASSERT_NEXT(a_push_shows, push, main_v_reg)

endmodule

[hw/rtl/crc16_packet_deframer_core.sv]
// length-prefixed frame parser with crc-16/ccitt-false check
// a result word is registered in the output buffer before it reaches the master side
// throughput: one byte per cycle; a two-word output buffer keeps input open under stall
// input stalls only once both output slots are full
// reset: asynchronous active-low rst_n; parser waits for the start marker, buffer empty,
// registers return to start marker 0xAA and payload limit 256
module crc16_packet_deframer_core #(
    parameter int MAX_PAYLOAD = cpd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data,
    // receive stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [7:0] command, [23:8] frame_length, [31:24] data_byte,
                                   // [39:32] byte_index, [55:40] computed_crc,
                                   // [71:56] received_crc
    output logic [1:0]  m_tuser,   // [1:0] event_res
    output logic        m_tlast
);

    logic [7:0]    start_marker_reg;
    logic [8:0]    payload_limit_reg;
    logic          in_fire;
    logic          res_valid;
    cpd_pkg::res_t res;
    cpd_pkg::res_t out_word;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg  <= cpd_pkg::START_MARKER_RST;
            payload_limit_reg <= cpd_pkg::PAYLOAD_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cpd_pkg::REG_START_MARKER:  start_marker_reg  <= cfg_data[7:0];
                cpd_pkg::REG_PAYLOAD_LIMIT: payload_limit_reg <= cfg_data;
                default:                    start_marker_reg  <= start_marker_reg;
            endcase
        end
    end

    assign in_fire = s_tvalid && s_tready;

    cpd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .rx_byte       (s_tdata),
        .start_marker  (start_marker_reg),
        .payload_limit (payload_limit_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    cpd_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_word)
    );

    // pack result word onto the stream
    assign m_tdata = {out_word.received_crc, out_word.computed_crc, out_word.byte_index,
                      out_word.data_byte, out_word.frame_length, out_word.command};
    assign m_tuser = out_word.event_res;
    assign m_tlast = out_word.last;

endmodule
